FILE: hw/rtl/fpw_pkg.sv
// ----------------------------------------------------------------------------
// fpw_pkg: shared constants and helpers
// Sizes of the word buffer, the byte position and the result fields of the
// first palindromic word finder.
// ----------------------------------------------------------------------------
package fpw_pkg;

  localparam int MAX_WORD = 32;
  localparam int POS_BITS = 16;
  localparam int CNT_W    = $clog2(MAX_WORD + 1);
  localparam int IDX_W    = $clog2(MAX_WORD);
  localparam int CH_W     = 8;
  localparam int OFS_W    = 16;
  localparam int LEN_W    = 6;

  localparam logic [POS_BITS-1:0] POS_TOP = '1;

  localparam logic [CH_W-1:0] CH_NUL = 8'h00;

  // ASCII letter test, case kept apart
  function automatic logic is_letter(input logic [CH_W-1:0] c);
    logic upper;
    logic lower;
    upper = (c >= 8'h41) && (c <= 8'h5A);
    lower = (c >= 8'h61) && (c <= 8'h7A);
    return upper || lower;
  endfunction

endpackage

FILE: hw/rtl/fpw_ifs.sv
// ----------------------------------------------------------------------------
// fpw channel interfaces
// Valid/ready channels for the byte stream and for the search result.
// ----------------------------------------------------------------------------
interface fpw_in_if;
  logic                      valid;
  logic                      ready;
  logic [fpw_pkg::CH_W-1:0]  ch;
  logic                      last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface fpw_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [fpw_pkg::OFS_W-1:0] offset;
  logic [fpw_pkg::LEN_W-1:0] word_length;
  logic                      overflow;

  modport source (output valid, found, offset, word_length, overflow, input ready);
  modport sink   (input valid, found, offset, word_length, overflow, output ready);
endinterface

FILE: hw/rtl/fpw_word_buf.sv
// ----------------------------------------------------------------------------
// fpw_word_buf: word buffer with mirror check
// Keeps the current word twice: in write order and as a shift line that holds
// it reversed. The word reads the same backwards when both copies agree at
// every place below the word length, so each compare sits at a fixed place.
// ----------------------------------------------------------------------------
module fpw_word_buf (
  input  logic                       clk,
  input  logic                       wr,
  input  logic [fpw_pkg::CH_W-1:0]   ch,
  input  logic [fpw_pkg::CNT_W-1:0]  cnt,
  input  logic [fpw_pkg::CNT_W-1:0]  cnt_eff,
  output logic                       mirror
);

  logic [fpw_pkg::CH_W-1:0] fwd_r [fpw_pkg::MAX_WORD];
  logic [fpw_pkg::CH_W-1:0] rev_r [fpw_pkg::MAX_WORD];
  logic [fpw_pkg::CH_W-1:0] fwd_eff [fpw_pkg::MAX_WORD];
  logic [fpw_pkg::CH_W-1:0] rev_eff [fpw_pkg::MAX_WORD];
  logic [fpw_pkg::MAX_WORD-1:0] agree;

  // store the letter: forward copy at its index, reversed copy at the head
  always_ff @(posedge clk) begin
    if (wr) begin
      fwd_r[cnt[fpw_pkg::IDX_W-1:0]] <= ch;
      rev_r[0] <= ch;
      for (int j = 1; j < fpw_pkg::MAX_WORD; j++) begin
        rev_r[j] <= rev_r[j-1];
      end
    end
  end

  // view both copies as they stand with this beat's letter included
  always_comb begin
    for (int j = 0; j < fpw_pkg::MAX_WORD; j++) begin
      fwd_eff[j] = (wr && (cnt == fpw_pkg::CNT_W'(j))) ? ch : fwd_r[j];
      if (wr) begin
        rev_eff[j] = (j == 0) ? ch : rev_r[(j == 0) ? 0 : j-1];
      end else begin
        rev_eff[j] = rev_r[j];
      end
      agree[j] = (fpw_pkg::CNT_W'(j) >= cnt_eff) || (fwd_eff[j] == rev_eff[j]);
    end
  end

  assign mirror = &agree;

endmodule

FILE: hw/rtl/first_palindrome_word_finder_top.sv
// ----------------------------------------------------------------------------
// first_palindrome_word_finder_top: first palindromic word in a byte string
// Scans a string one byte per beat and reports the first palindromic word.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one byte of the string per beat (ch) and last on the
//   final byte. out_chan carries exactly one result per string, for the beat
//   with last set: found, offset and word_length of the first word of ASCII
//   letters that reads the same backwards (case matters), and overflow for a
//   word longer than 32 letters or a byte index past 65535.
//   A zero byte ends the string early; later bytes up to last are ignored.
//   Timing: a byte is taken into the input register, scanned from there by
//   the state update and the parallel mirror compare, and the result of a
//   final byte lands in the output register. One byte per cycle is sustained
//   unless a final byte waits on a full result slot; the mirror compare
//   across the 32-byte word buffer sets the cycle.
//   Stall: while out_ready is low a finished result holds in the output
//   register; non-final bytes keep flowing, and a further final byte waits in
//   the input register, which then drops in_ready.
//   Reset clears all scan state and empties both registers. After each final
//   byte the scan state returns to its reset value for the next string.
// ----------------------------------------------------------------------------
module first_palindrome_word_finder_top (
  input  logic         clk,
  input  logic         rst_n,
  fpw_in_if.sink       in_chan,
  fpw_out_if.source    out_chan
);

  // input register
  logic                       in_vld_r;
  logic [fpw_pkg::CH_W-1:0]   ch_r;
  logic                       last_r;
  logic                       adv;

  // scan state
  logic [fpw_pkg::POS_BITS-1:0] position_r, position_nxt;
  logic                         pos_full_r, pos_full_nxt;
  logic [fpw_pkg::POS_BITS-1:0] word_start_r, word_start_nxt;
  logic [fpw_pkg::CNT_W-1:0]    word_count_r, word_count_nxt;
  logic                         word_over_r, word_over_nxt;
  logic                         hit_r, hit_nxt;
  logic [fpw_pkg::POS_BITS-1:0] hit_offset_r, hit_offset_nxt;
  logic [fpw_pkg::CNT_W-1:0]    hit_length_r, hit_length_nxt;
  logic                         too_long_r, too_long_nxt;
  logic                         ended_r, ended_nxt;

  // result register
  logic                       out_vld_r;
  logic                       found_r;
  logic [fpw_pkg::OFS_W-1:0]  offset_r;
  logic [fpw_pkg::LEN_W-1:0]  length_r;
  logic                       overflow_r;

  // scan helpers
  logic                         active;
  logic                         letter;
  logic                         is_nul;
  logic                         wr;
  logic                         close;
  logic                         mirror;
  logic [fpw_pkg::POS_BITS-1:0] idx;
  logic [fpw_pkg::CNT_W-1:0]    cnt_eff;
  logic                         over_eff;
  logic [fpw_pkg::POS_BITS-1:0] start_eff;

  // advance the held byte unless it is final and the result slot is full and not being taken
  assign adv = in_vld_r && (!last_r || !out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      ch_r   <= in_chan.ch;
      last_r <= in_chan.last;
    end
  end

  // classify the held byte
  assign active    = !ended_r && !hit_r;
  assign letter    = fpw_pkg::is_letter(ch_r);
  assign is_nul    = (ch_r == fpw_pkg::CH_NUL);
  assign idx       = pos_full_r ? fpw_pkg::POS_TOP : position_r;
  assign wr        = adv && active && letter &&
                     (word_count_r < fpw_pkg::CNT_W'(fpw_pkg::MAX_WORD));
  assign cnt_eff   = word_count_r + fpw_pkg::CNT_W'(wr);
  assign over_eff  = word_over_r || (active && letter &&
                     (word_count_r == fpw_pkg::CNT_W'(fpw_pkg::MAX_WORD)));
  assign start_eff = (active && letter && (word_count_r == '0) && !word_over_r)
                     ? idx : word_start_r;
  assign close     = active && (!letter || last_r);

  fpw_word_buf u_word_buf (
    .clk     (clk),
    .wr      (wr),
    .ch      (ch_r),
    .cnt     (word_count_r),
    .cnt_eff (cnt_eff),
    .mirror  (mirror)
  );

  // next scan state for the held byte
  always_comb begin
    position_nxt   = position_r;
    pos_full_nxt   = pos_full_r;
    word_start_nxt = word_start_r;
    word_count_nxt = word_count_r;
    word_over_nxt  = word_over_r;
    hit_nxt        = hit_r;
    hit_offset_nxt = hit_offset_r;
    hit_length_nxt = hit_length_r;
    too_long_nxt   = too_long_r;
    ended_nxt      = ended_r;
    if (active) begin
      if (pos_full_r) begin
        too_long_nxt = 1'b1;
      end else if (position_r == fpw_pkg::POS_TOP) begin
        pos_full_nxt = 1'b1;
      end else begin
        position_nxt = position_r + fpw_pkg::POS_BITS'(1);
      end
      word_start_nxt = start_eff;
      word_count_nxt = cnt_eff;
      word_over_nxt  = over_eff;
      if (is_nul) begin
        ended_nxt = 1'b1;
      end
      if (close) begin
        if (over_eff) begin
          too_long_nxt = 1'b1;
        end else if ((cnt_eff != '0) && mirror) begin
          hit_nxt        = 1'b1;
          hit_offset_nxt = start_eff;
          hit_length_nxt = cnt_eff;
        end
        word_count_nxt = '0;
        word_over_nxt  = 1'b0;
      end
    end
  end

  // commit the scan; a final byte returns everything to reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      pos_full_r   <= 1'b0;
      word_start_r <= '0;
      word_count_r <= '0;
      word_over_r  <= 1'b0;
      hit_r        <= 1'b0;
      hit_offset_r <= '0;
      hit_length_r <= '0;
      too_long_r   <= 1'b0;
      ended_r      <= 1'b0;
    end else if (adv) begin
      if (last_r) begin
        position_r   <= '0;
        pos_full_r   <= 1'b0;
        word_start_r <= '0;
        word_count_r <= '0;
        word_over_r  <= 1'b0;
        hit_r        <= 1'b0;
        hit_offset_r <= '0;
        hit_length_r <= '0;
        too_long_r   <= 1'b0;
        ended_r      <= 1'b0;
      end else begin
        position_r   <= position_nxt;
        pos_full_r   <= pos_full_nxt;
        word_start_r <= word_start_nxt;
        word_count_r <= word_count_nxt;
        word_over_r  <= word_over_nxt;
        hit_r        <= hit_nxt;
        hit_offset_r <= hit_offset_nxt;
        hit_length_r <= hit_length_nxt;
        too_long_r   <= too_long_nxt;
        ended_r      <= ended_nxt;
      end
    end
  end

  // result register: load on a final byte, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_r) begin
      found_r    <= hit_nxt;
      offset_r   <= hit_nxt ? fpw_pkg::OFS_W'(hit_offset_nxt) : '0;
      length_r   <= hit_nxt ? fpw_pkg::LEN_W'(hit_length_nxt) : '0;
      overflow_r <= too_long_nxt;
    end
  end

  assign out_chan.valid       = out_vld_r;
  assign out_chan.found       = found_r;
  assign out_chan.offset      = offset_r;
  assign out_chan.word_length = length_r;
  assign out_chan.overflow    = overflow_r;

  // checks
  a_found_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && found_r) |->
      (length_r != '0) && (length_r <= fpw_pkg::LEN_W'(fpw_pkg::MAX_WORD)))
    else $error("found result with bad word length");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !found_r) |-> (offset_r == '0) && (length_r == '0))
    else $error("empty result carries offset or length");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    word_count_r <= fpw_pkg::CNT_W'(fpw_pkg::MAX_WORD))
    else $error("word count beyond buffer size");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last_r) |=> (position_r == '0) && !hit_r && !too_long_r && out_vld_r)
    else $error("scan state not cleared after final byte");

endmodule
